/* rtl/m4inv_pkg.sv */
// ----------------------------------------------------------------------------
// m4inv_pkg
// Shared types, constants and the cofactor term table of the 4x4 inverse core.
// ----------------------------------------------------------------------------
package m4inv_pkg;

    localparam int ELEMENT_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF     = 16;

    localparam logic [3:0] IDX_LAST  = 4'd15;
    localparam logic [2:0] TERM_LAST = 3'd5;
    localparam logic [1:0] ROW_LAST  = 2'd3;

    typedef struct packed {
        logic [3:0] a;
        logic [3:0] b;
        logic [3:0] c;
        logic       neg;
    } t_term;

    typedef struct packed {
        logic       mat_we;
        logic [3:0] mat_waddr;
        logic [3:0] mat_raddr;
        logic       x_mat;
        logic       x_prod;
        logic       x_adj;
        logic       mul_go;
        logic       cof_clr;
        logic       cof_acc;
        logic       cof_neg;
        logic       adj_we;
        logic [3:0] adj_addr;
        logic       det_clr;
        logic       det_acc;
        logic       det_latch;
        logic       div_go;
        logic       emit;
        logic       emit_sing;
        logic [3:0] emit_idx;
        logic       emit_last;
    } t_cmd;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic det_zero;
    } t_stat;

    // Term t of signed cofactor k (adjugate order): three element indices and sign.
    function automatic t_term term_sel(logic [3:0] k, logic [2:0] t);
        logic [1:0] dr;
        logic [1:0] dc;
        logic [1:0] rs0;
        logic [1:0] rs1;
        logic [1:0] rs2;
        logic [1:0] cs [0:2];
        logic [1:0] p0;
        logic [1:0] p1;
        logic [1:0] p2;
        logic       sg;
        t_term      res;
        dr = k[1:0];
        dc = k[3:2];
        rs0   = (dr == 2'd0) ? 2'd1 : 2'd0;
        rs1   = (dr <= 2'd1) ? 2'd2 : 2'd1;
        rs2   = (dr <= 2'd2) ? 2'd3 : 2'd2;
        cs[0] = (dc == 2'd0) ? 2'd1 : 2'd0;
        cs[1] = (dc <= 2'd1) ? 2'd2 : 2'd1;
        cs[2] = (dc <= 2'd2) ? 2'd3 : 2'd2;
        case (t)
            3'd1: begin p0 = 2'd0; p1 = 2'd2; p2 = 2'd1; sg = 1'b1; end
            3'd2: begin p0 = 2'd1; p1 = 2'd0; p2 = 2'd2; sg = 1'b1; end
            3'd3: begin p0 = 2'd1; p1 = 2'd2; p2 = 2'd0; sg = 1'b0; end
            3'd4: begin p0 = 2'd2; p1 = 2'd0; p2 = 2'd1; sg = 1'b0; end
            3'd5: begin p0 = 2'd2; p1 = 2'd1; p2 = 2'd0; sg = 1'b1; end
            default: begin p0 = 2'd0; p1 = 2'd1; p2 = 2'd2; sg = 1'b0; end
        endcase
        res.a   = {rs0, cs[p0]};
        res.b   = {rs1, cs[p1]};
        res.c   = {rs2, cs[p2]};
        res.neg = sg ^ k[0] ^ k[2];
        return res;
    endfunction

endpackage

/* rtl/m4inv_ram.sv */
// ----------------------------------------------------------------------------
// m4inv_ram
// Generic simple dual-port RAM, one write port, registered read.
// ----------------------------------------------------------------------------
module m4inv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

/* rtl/m4inv_ctrl.sv */
// ----------------------------------------------------------------------------
// m4inv_ctrl
// Sequencer: load, cofactor terms, determinant, per-element division.
// ----------------------------------------------------------------------------
module m4inv_ctrl import m4inv_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    output logic  o_busy,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_COF_INIT, S_RA, S_RB, S_MB, S_W1, S_MC, S_W2, S_ACC, S_COF_WR,
        S_DET_INIT, S_DA, S_DB, S_DW, S_DACC, S_DCHK, S_QA, S_QB, S_QW, S_QOUT
    } t_state;

    t_state     r_state;
    logic [3:0] r_load;
    logic [3:0] r_k;
    logic [2:0] r_t;
    logic [1:0] r_j;
    t_term      term;

    assign term   = term_sel(r_k, r_t);
    assign o_busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_load  <= '0;
            r_k     <= '0;
            r_t     <= '0;
            r_j     <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        if (r_load == IDX_LAST) begin
                            r_load  <= '0;
                            r_k     <= '0;
                            r_state <= S_COF_INIT;
                        end else begin
                            r_load <= r_load + 4'd1;
                        end
                    end
                end
                S_COF_INIT: begin
                    r_t     <= '0;
                    r_state <= S_RA;
                end
                S_RA: r_state <= S_RB;
                S_RB: r_state <= S_MB;
                S_MB: r_state <= S_W1;
                S_W1: if (i_stat.mul_done) r_state <= S_MC;
                S_MC: r_state <= S_W2;
                S_W2: if (i_stat.mul_done) r_state <= S_ACC;
                S_ACC: begin
                    if (r_t == TERM_LAST) begin
                        r_state <= S_COF_WR;
                    end else begin
                        r_t     <= r_t + 3'd1;
                        r_state <= S_RA;
                    end
                end
                S_COF_WR: begin
                    if (r_k == IDX_LAST) begin
                        r_j     <= '0;
                        r_state <= S_DET_INIT;
                    end else begin
                        r_k     <= r_k + 4'd1;
                        r_state <= S_COF_INIT;
                    end
                end
                S_DET_INIT: r_state <= S_DA;
                S_DA: r_state <= S_DB;
                S_DB: r_state <= S_DW;
                S_DW: if (i_stat.mul_done) r_state <= S_DACC;
                S_DACC: begin
                    if (r_j == ROW_LAST) begin
                        r_state <= S_DCHK;
                    end else begin
                        r_j     <= r_j + 2'd1;
                        r_state <= S_DA;
                    end
                end
                S_DCHK: begin
                    r_k     <= '0;
                    r_state <= i_stat.det_zero ? S_IDLE : S_QA;
                end
                S_QA: r_state <= S_QB;
                S_QB: r_state <= S_QW;
                S_QW: if (i_stat.div_done) r_state <= S_QOUT;
                S_QOUT: begin
                    if (r_k == IDX_LAST) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_k     <= r_k + 4'd1;
                        r_state <= S_QA;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.mat_waddr = r_load;
        o_cmd.mat_raddr = term.c;
        o_cmd.adj_addr  = r_k;
        o_cmd.cof_neg   = term.neg;
        o_cmd.emit_idx  = r_k;
        o_cmd.emit_last = (r_k == IDX_LAST);
        case (r_state)
            S_IDLE:     o_cmd.mat_we = i_start;
            S_COF_INIT: o_cmd.cof_clr = 1'b1;
            S_RA:       o_cmd.mat_raddr = term.a;
            S_RB: begin
                o_cmd.mat_raddr = term.b;
                o_cmd.x_mat     = 1'b1;
            end
            S_MB:       o_cmd.mul_go = 1'b1;
            S_MC: begin
                o_cmd.x_prod = 1'b1;
                o_cmd.mul_go = 1'b1;
            end
            S_ACC:      o_cmd.cof_acc = 1'b1;
            S_COF_WR:   o_cmd.adj_we = 1'b1;
            S_DET_INIT: o_cmd.det_clr = 1'b1;
            S_DA, S_DW, S_DACC: begin
                o_cmd.mat_raddr = {2'b00, r_j};
                o_cmd.adj_addr  = {r_j, 2'b00};
                o_cmd.det_acc   = (r_state == S_DACC);
            end
            S_DB: begin
                o_cmd.mat_raddr = {2'b00, r_j};
                o_cmd.adj_addr  = {r_j, 2'b00};
                o_cmd.x_adj     = 1'b1;
                o_cmd.mul_go    = 1'b1;
            end
            S_DCHK: begin
                o_cmd.det_latch = 1'b1;
                o_cmd.emit_sing = i_stat.det_zero;
            end
            S_QB:       o_cmd.div_go = 1'b1;
            S_QOUT:     o_cmd.emit = 1'b1;
            default: ;
        endcase
    end

endmodule

/* rtl/m4inv_dpath.sv */
// ----------------------------------------------------------------------------
// m4inv_dpath
// Element and cofactor stores, shift-add multiplier, accumulators,
// restoring divider and result register.
// ----------------------------------------------------------------------------
module m4inv_dpath import m4inv_pkg::*; #(
    parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF,
    parameter int FRAC_BITS     = FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  t_cmd                            i_cmd,
    output t_stat                           o_stat,
    input  logic signed [ELEMENT_WIDTH-1:0] i_element_value,
    output logic                            o_strobe,
    output logic signed [ELEMENT_WIDTH-1:0] o_inverse_value,
    output logic [3:0]                      o_element_index,
    output logic                            o_singular,
    output logic                            o_saturated,
    output logic                            o_last_result
);

    localparam int W   = ELEMENT_WIDTH;
    localparam int CW  = 3 * W + 1;
    localparam int MW  = 3 * W;
    localparam int DW  = 4 * W + 2;
    localparam int DMW = 4 * W + 1;
    localparam int NW  = 3 * W + 2 * FRAC_BITS;
    localparam int MCW = $clog2(W + 1);
    localparam int DCW = $clog2(NW + 1);

    logic [W-1:0]   mat_q;
    logic [CW-1:0]  adj_q;

    logic [DW-1:0]  r_x;
    logic [DW-1:0]  r_acc;
    logic [W-1:0]   r_ym;
    logic           r_ysgn;
    logic [MCW-1:0] r_mcnt;
    logic [DW-1:0]  p_val;
    logic [W-1:0]   y_neg;

    logic [CW-1:0]  r_cof;
    logic [DW-1:0]  r_det;
    logic [DW-1:0]  det_neg;
    logic [DMW-1:0] r_dmag;
    logic           r_dneg;

    logic [NW-1:0]  r_num;
    logic [DMW-1:0] r_rem;
    logic           r_nneg;
    logic [DCW-1:0] r_dcnt;
    logic [CW-1:0]  adj_neg;
    logic [MW-1:0]  amag;
    logic [DMW:0]   sh;
    logic [DMW:0]   diff;
    logic           ge;

    logic           q_neg;
    logic [NW-1:0]  lim;
    logic           sat;
    logic [NW-1:0]  qsel;
    logic [W-1:0]   qval;

    logic           r_strobe;
    logic [W-1:0]   r_val;
    logic [3:0]     r_idx;
    logic           r_sing;
    logic           r_sat;
    logic           r_last;

    m4inv_ram #(.WIDTH(W), .DEPTH(16)) u_mat (
        .i_clk   (i_clk),
        .i_we    (i_cmd.mat_we),
        .i_waddr (i_cmd.mat_waddr),
        .i_wdata (i_element_value),
        .i_raddr (i_cmd.mat_raddr),
        .o_rdata (mat_q)
    );

    m4inv_ram #(.WIDTH(CW), .DEPTH(16)) u_adj (
        .i_clk   (i_clk),
        .i_we    (i_cmd.adj_we),
        .i_waddr (i_cmd.adj_addr),
        .i_wdata (r_cof),
        .i_raddr (i_cmd.adj_addr),
        .o_rdata (adj_q)
    );

    // multiplier: one multiplier bit per cycle
    assign p_val = r_ysgn ? (~r_acc + 1'b1) : r_acc;
    assign y_neg = ~mat_q + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mcnt <= '0;
        end else if (i_cmd.mul_go) begin
            r_mcnt <= MCW'(W);
        end else if (r_mcnt != '0) begin
            r_mcnt <= r_mcnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.x_mat) begin
            r_x <= {{(DW-W){mat_q[W-1]}}, mat_q};
        end else if (i_cmd.x_prod) begin
            r_x <= p_val;
        end else if (i_cmd.x_adj) begin
            r_x <= {{(DW-CW){adj_q[CW-1]}}, adj_q};
        end else if (r_mcnt != '0) begin
            r_x <= {r_x[DW-2:0], 1'b0};
        end
        if (i_cmd.mul_go) begin
            r_acc  <= '0;
            r_ym   <= mat_q[W-1] ? y_neg : mat_q;
            r_ysgn <= mat_q[W-1];
        end else if (r_mcnt != '0) begin
            if (r_ym[0]) begin
                r_acc <= r_acc + r_x;
            end
            r_ym <= {1'b0, r_ym[W-1:1]};
        end
    end

    // cofactor and determinant accumulators
    assign det_neg = ~r_det + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.cof_clr) begin
            r_cof <= '0;
        end else if (i_cmd.cof_acc) begin
            r_cof <= i_cmd.cof_neg ? (r_cof - p_val[CW-1:0]) : (r_cof + p_val[CW-1:0]);
        end
        if (i_cmd.det_clr) begin
            r_det <= '0;
        end else if (i_cmd.det_acc) begin
            r_det <= r_det + p_val;
        end
        if (i_cmd.det_latch) begin
            r_dneg <= r_det[DW-1];
            r_dmag <= r_det[DW-1] ? det_neg[DMW-1:0] : r_det[DMW-1:0];
        end
    end

    // restoring divider: one quotient bit per cycle, quotient shifts into r_num
    assign adj_neg = ~adj_q + 1'b1;
    assign amag    = adj_q[CW-1] ? adj_neg[MW-1:0] : adj_q[MW-1:0];
    assign sh      = {r_rem, r_num[NW-1]};
    assign diff    = sh - {1'b0, r_dmag};
    assign ge      = (sh >= {1'b0, r_dmag});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcnt <= '0;
        end else if (i_cmd.div_go) begin
            r_dcnt <= DCW'(NW);
        end else if (r_dcnt != '0) begin
            r_dcnt <= r_dcnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_go) begin
            r_num  <= {amag, {(2*FRAC_BITS){1'b0}}};
            r_rem  <= '0;
            r_nneg <= adj_q[CW-1];
        end else if (r_dcnt != '0) begin
            r_rem <= ge ? diff[DMW-1:0] : sh[DMW-1:0];
            r_num <= {r_num[NW-2:0], ge};
        end
    end

    // saturation and sign
    assign q_neg = r_nneg ^ r_dneg;
    assign lim   = {{(NW-W){1'b0}}, 1'b1, {(W-1){1'b0}}} - {{(NW-1){1'b0}}, ~q_neg};
    assign sat   = (r_num > lim);
    assign qsel  = sat ? lim : r_num;
    assign qval  = q_neg ? (~qsel[W-1:0] + 1'b1) : qsel[W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit | i_cmd.emit_sing;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_val  <= qval;
            r_idx  <= i_cmd.emit_idx;
            r_sing <= 1'b0;
            r_sat  <= sat;
            r_last <= i_cmd.emit_last;
        end else if (i_cmd.emit_sing) begin
            r_val  <= '0;
            r_idx  <= '0;
            r_sing <= 1'b1;
            r_sat  <= 1'b0;
            r_last <= 1'b1;
        end
    end

    assign o_stat.mul_done = (r_mcnt == '0);
    assign o_stat.div_done = (r_dcnt == '0);
    assign o_stat.det_zero = (r_det == '0);

    assign o_strobe        = r_strobe;
    assign o_inverse_value = r_val;
    assign o_element_index = r_idx;
    assign o_singular      = r_sing;
    assign o_saturated     = r_sat;
    assign o_last_result   = r_last;

endmodule

/* rtl/matrix4x4_inverse_core.sv */
// ----------------------------------------------------------------------------
// matrix4x4_inverse_core
// 4x4 signed fixed-point matrix inverse by exact cofactors and direct division.
// ----------------------------------------------------------------------------
// Words are loaded one per cycle while o_busy is low (i_start high), row-major.
// After the sixteenth word the core goes busy; its run time is set by the
// shift-add multiplier (one bit per cycle, two passes per cofactor term,
// 96 terms) and the restoring divider (one quotient bit per cycle, 16
// divisions). Results come as single-cycle o_strobe pulses that the
// receiver must take as they come: one singular word, or 16 inverse
// words in row-major order.
module matrix4x4_inverse_core import m4inv_pkg::*; #(
    parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF,
    parameter int FRAC_BITS     = FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    output logic                            o_busy,
    input  logic signed [ELEMENT_WIDTH-1:0] i_element_value,
    output logic                            o_strobe,
    output logic signed [ELEMENT_WIDTH-1:0] o_inverse_value,
    output logic [3:0]                      o_element_index,
    output logic                            o_singular,
    output logic                            o_saturated,
    output logic                            o_last_result
);

    t_cmd  cmd;
    t_stat stat;

    m4inv_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .o_busy  (o_busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    m4inv_dpath #(
        .ELEMENT_WIDTH (ELEMENT_WIDTH),
        .FRAC_BITS     (FRAC_BITS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_element_value (i_element_value),
        .o_strobe        (o_strobe),
        .o_inverse_value (o_inverse_value),
        .o_element_index (o_element_index),
        .o_singular      (o_singular),
        .o_saturated     (o_saturated),
        .o_last_result   (o_last_result)
    );

endmodule

/* rtl/m4inv_chk.sv */
// ----------------------------------------------------------------------------
// m4inv_chk
// Port-level checks of the result sequence of the inverse core.
// ----------------------------------------------------------------------------
module m4inv_chk import m4inv_pkg::*; #(
    parameter int W = ELEMENT_WIDTH_DEF
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_busy,
    input logic                o_strobe,
    input logic signed [W-1:0] o_inverse_value,
    input logic [3:0]          o_element_index,
    input logic                o_singular,
    input logic                o_saturated,
    input logic                o_last_result
);

    a_spaced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("back-to-back result words");

    a_sing_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_singular |-> o_last_result && !o_saturated &&
        o_inverse_value == '0 && o_element_index == '0)
        else $error("malformed singular word");

    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_singular && o_last_result |-> o_element_index == IDX_LAST)
        else $error("last flag on wrong element");

    a_busy_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_last_result == !o_busy))
        else $error("busy does not track final word");

endmodule

bind matrix4x4_inverse_core m4inv_chk #(.W(ELEMENT_WIDTH)) u_m4inv_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_busy          (o_busy),
    .o_strobe        (o_strobe),
    .o_inverse_value (o_inverse_value),
    .o_element_index (o_element_index),
    .o_singular      (o_singular),
    .o_saturated     (o_saturated),
    .o_last_result   (o_last_result)
);
